>>> hdl/erfs_pkg.sv
// Package for the escaped record field splitter.
// Holds the byte codes, result kinds, the queue entry type and default sizes.
// Used by the interfaces and by every module of the block.
package erfs_pkg;

  localparam int BYTE_W = 8;
  localparam int COUNT_WIDTH_DEF = 8;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam logic [BYTE_W-1:0] ESC_BYTE = 8'h1B;
  localparam logic [BYTE_W-1:0] FS_BYTE = 8'h1F;
  localparam logic [BYTE_W-1:0] RS_BYTE = 8'h1E;
  localparam logic [BYTE_W-1:0] MAX_FIELDS_RESET = 8'd64;

  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_FIELD_END = 2'd1,
    KIND_RECORD_END = 2'd2
  } kind_t;

  // One queue entry holds every result that a single input byte causes,
  // in the order data, field end, record end.
  typedef struct packed {
    logic has_data;
    logic has_close;
    logic has_rec;
    logic [BYTE_W-1:0] data;
    logic [BYTE_W-1:0] num;
    logic [BYTE_W-1:0] count;
  } bundle_t;

  localparam int PART_W = 3;

endpackage

>>> hdl/erfs_ifs.sv
// Channel interfaces of the escaped record field splitter.
// Byte input, result output and configuration write; depends on erfs_pkg.
interface erfs_byte_if;
  logic valid;
  logic ready;
  logic [erfs_pkg::BYTE_W-1:0] data_byte;
  logic end_of_record;
  modport source(output valid, data_byte, end_of_record, input ready);
  modport sink(input valid, data_byte, end_of_record, output ready);
endinterface

interface erfs_item_if;
  logic valid;
  logic ready;
  erfs_pkg::kind_t item_kind;
  logic [erfs_pkg::BYTE_W-1:0] out_byte;
  logic [erfs_pkg::BYTE_W-1:0] field_number;
  logic run_last;
  modport source(output valid, item_kind, out_byte, field_number, run_last, input ready);
  modport sink(input valid, item_kind, out_byte, field_number, run_last, output ready);
endinterface

interface erfs_cfg_if;
  logic valid;
  logic ready;
  logic [erfs_pkg::BYTE_W-1:0] max_fields;
  modport source(output valid, max_fields, input ready);
  modport sink(input valid, max_fields, output ready);
endinterface

>>> hdl/escaped_record_field_splitter_unit.sv
// Top level of the escaped record field splitter.
// Connects front end, entry queue and back end; depends on erfs_pkg and erfs_ifs.
//
//   Channel       Dir  Signals                                        Request
//   byte_stream   in   data_byte, end_of_record                      one encoded byte
//   item_stream   out  item_kind, out_byte, field_number, run_last  one result
//   cfg           in   max_fields                                     one register write
//
// Each result leaves through the back end's single output register; a byte
// yields up to three results: data, field end and record end.
// Bytes keep flowing while the queue has room, even with results stalled.
// Synchronous reset clears all state and sets max_fields to 64.
// The configuration channel is always ready.
module escaped_record_field_splitter_unit #(
  parameter int COUNT_WIDTH = erfs_pkg::COUNT_WIDTH_DEF,
  parameter int QUEUE_DEPTH = erfs_pkg::QUEUE_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst,
  erfs_byte_if.sink byte_stream,
  erfs_cfg_if.sink cfg,
  erfs_item_if.source item_stream
);

  logic q_push, q_full, q_pop, q_empty;
  erfs_pkg::bundle_t q_data, q_head;

  erfs_front #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .byte_stream(byte_stream),
    .cfg(cfg),
    .q_full(q_full),
    .q_push(q_push),
    .q_data(q_data)
  );

  erfs_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk(clk),
    .rst(rst),
    .push(q_push),
    .push_data(q_data),
    .full(q_full),
    .pop(q_pop),
    .empty(q_empty),
    .head(q_head)
  );

  erfs_back u_back (
    .clk(clk),
    .rst(rst),
    .q_empty(q_empty),
    .head(q_head),
    .q_pop(q_pop),
    .item_stream(item_stream)
  );

endmodule

>>> hdl/erfs_front.sv
// Front end: accepts bytes, tracks escape, separator and field count state,
// and pushes one entry per byte that causes results. Depends on erfs_pkg.
module erfs_front #(
  parameter int COUNT_WIDTH = erfs_pkg::COUNT_WIDTH_DEF
) (
  input  logic clk,
  input  logic rst,
  erfs_byte_if.sink byte_stream,
  erfs_cfg_if.sink cfg,
  input  logic q_full,
  output logic q_push,
  output erfs_pkg::bundle_t q_data
);

  localparam int BW = erfs_pkg::BYTE_W;
  localparam int CMP_W = (COUNT_WIDTH > BW) ? COUNT_WIDTH : BW;

  logic [BW-1:0] max_fields;
  logic escape_pending, escape_pending_next;
  logic after_separator, after_separator_next;
  logic [COUNT_WIDTH-1:0] fields_done, fields_done_next;
  logic [COUNT_WIDTH-1:0] fd_inc;
  logic accept, active, is_sep, open_final;
  erfs_pkg::bundle_t b;

  assign cfg.ready = 1'b1;
  assign byte_stream.ready = !q_full;
  assign accept = byte_stream.valid && !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_fields <= erfs_pkg::MAX_FIELDS_RESET;
    end else if (cfg.valid) begin
      max_fields <= cfg.max_fields;
    end
  end

  assign fd_inc = fields_done + COUNT_WIDTH'(1);
  assign active = (CMP_W'(fields_done) < CMP_W'(max_fields)) && (fields_done != '1);
  assign is_sep = (byte_stream.data_byte == erfs_pkg::FS_BYTE) ||
                  (byte_stream.data_byte == erfs_pkg::RS_BYTE);

  always_comb begin
    escape_pending_next = escape_pending;
    after_separator_next = after_separator;
    fields_done_next = fields_done;
    open_final = 1'b1;
    b = '0;
    b.data = byte_stream.data_byte;
    b.num = BW'(fields_done);
    b.count = BW'(fields_done);
    if (!byte_stream.end_of_record) begin
      if (escape_pending) begin
        escape_pending_next = 1'b0;
        after_separator_next = 1'b0;
        b.has_data = active;
      end else if (byte_stream.data_byte == erfs_pkg::ESC_BYTE) begin
        escape_pending_next = 1'b1;
        after_separator_next = 1'b0;
      end else if (is_sep) begin
        if (active) begin
          b.has_close = 1'b1;
          after_separator_next = 1'b1;
          fields_done_next = fd_inc;
        end
      end else begin
        after_separator_next = 1'b0;
        b.has_data = active;
      end
    end else begin
      if (byte_stream.data_byte == erfs_pkg::RS_BYTE) begin
        open_final = !after_separator;
      end else if (escape_pending) begin
        b.has_data = active;
      end else if (byte_stream.data_byte == erfs_pkg::ESC_BYTE) begin
        open_final = 1'b1;
      end else if (byte_stream.data_byte == erfs_pkg::FS_BYTE) begin
        b.has_close = active;
        open_final = 1'b0;
      end else begin
        b.has_data = active;
      end
      if (open_final && active) begin
        b.has_close = 1'b1;
      end
      b.has_rec = 1'b1;
      if (b.has_close) begin
        b.count = BW'(fd_inc);
      end
      escape_pending_next = 1'b0;
      after_separator_next = 1'b0;
      fields_done_next = '0;
    end
  end

  assign q_data = b;
  assign q_push = accept && (b.has_data || b.has_close || b.has_rec);

  always_ff @(posedge clk) begin
    if (rst) begin
      escape_pending <= 1'b0;
      after_separator <= 1'b0;
      fields_done <= '0;
    end else if (accept) begin
      escape_pending <= escape_pending_next;
      after_separator <= after_separator_next;
      fields_done <= fields_done_next;
    end
  end

endmodule

>>> hdl/erfs_queue.sv
// Short queue of result entries between the front and back ends.
// Register array with read and write pointers; depends on erfs_pkg.
module erfs_queue #(
  parameter int DEPTH = erfs_pkg::QUEUE_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  erfs_pkg::bundle_t push_data,
  output logic full,
  input  logic pop,
  output logic empty,
  output erfs_pkg::bundle_t head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  erfs_pkg::bundle_t mem [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] fill;
  logic do_push, do_pop;

  assign full = (fill == CW'(DEPTH));
  assign empty = (fill == '0);
  assign do_push = push && !full;
  assign do_pop = pop && !empty;
  assign head = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        fill <= fill + CW'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - CW'(1);
      end
    end
  end

endmodule

>>> hdl/erfs_back.sv
// Back end: walks the head queue entry's results one per cycle, unless output
// stalls, into a registered output stage. Depends on erfs_pkg and erfs_ifs.
module erfs_back (
  input  logic clk,
  input  logic rst,
  input  logic q_empty,
  input  erfs_pkg::bundle_t head,
  output logic q_pop,
  erfs_item_if.source item_stream
);

  localparam int PW = erfs_pkg::PART_W;

  logic [PW-1:0] done, parts, left, pick;
  logic load, last;
  logic ovalid;
  erfs_pkg::kind_t okind;
  logic [erfs_pkg::BYTE_W-1:0] obyte, onum;
  logic olast;

  assign parts = {head.has_rec, head.has_close, head.has_data};
  assign left = parts & ~done;
  assign pick = left & (~left + PW'(1));
  assign last = ((left & ~pick) == '0);
  assign load = !q_empty && (!ovalid || item_stream.ready);
  assign q_pop = load && last;

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= '0;
      ovalid <= 1'b0;
    end else begin
      if (load) begin
        done <= last ? '0 : (done | pick);
        ovalid <= 1'b1;
      end else if (item_stream.ready) begin
        ovalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      olast <= last;
      unique case (1'b1)
        pick[0]: begin
          okind <= erfs_pkg::KIND_DATA;
          obyte <= head.data;
          onum <= head.num;
        end
        pick[1]: begin
          okind <= erfs_pkg::KIND_FIELD_END;
          obyte <= '0;
          onum <= head.num;
        end
        default: begin
          okind <= erfs_pkg::KIND_RECORD_END;
          obyte <= '0;
          onum <= head.count;
        end
      endcase
    end
  end

  assign item_stream.valid = ovalid;
  assign item_stream.item_kind = okind;
  assign item_stream.out_byte = obyte;
  assign item_stream.field_number = onum;
  assign item_stream.run_last = olast;

endmodule

>>> tb/escaped_record_field_splitter_unit_tb.sv
`timescale 1ns / 1ps
// Testbench for the escaped record field splitter: directed and random records
// under several field limits, checked against an in-bench decoder model.
// Depends on erfs_pkg, the channel interfaces and escaped_record_field_splitter_unit.
module escaped_record_field_splitter_unit_tb;

  typedef struct packed {
    erfs_pkg::kind_t kind;
    logic [erfs_pkg::BYTE_W-1:0] value;
    logic [erfs_pkg::BYTE_W-1:0] field_no;
    logic last;
  } field_item_t;

  class field_splitter_scoreboard;
    logic [erfs_pkg::BYTE_W-1:0] max_fields;
    bit escape_pending;
    bit after_separator;
    logic [erfs_pkg::BYTE_W-1:0] fields_done;
    field_item_t expected_items[$];
    field_item_t batch[$];
    int mismatches;

    function new();
      max_fields = erfs_pkg::MAX_FIELDS_RESET;
      escape_pending = 1'b0;
      after_separator = 1'b0;
      fields_done = '0;
      mismatches = 0;
    endfunction

    function void set_max_fields(logic [erfs_pkg::BYTE_W-1:0] limit);
      max_fields = limit;
    endfunction

    function bit pending();
      return expected_items.size() != 0;
    endfunction

    function void push_item(erfs_pkg::kind_t kind, logic [erfs_pkg::BYTE_W-1:0] value);
      batch.push_back('{kind, value, fields_done, 1'b0});
    endfunction

    function void close_field();
      push_item(erfs_pkg::KIND_FIELD_END, 8'h00);
      fields_done = fields_done + 8'd1;
    endfunction

    // With an 8-bit counter the saturated limit equals max_fields itself.
    function void note_request(logic [erfs_pkg::BYTE_W-1:0] data, logic eor);
      bit active;
      bit sep;
      bit open_final;
      batch.delete();
      active = fields_done < max_fields;
      sep = (data == erfs_pkg::FS_BYTE) || (data == erfs_pkg::RS_BYTE);
      if (!eor) begin
        if (escape_pending) begin
          escape_pending = 1'b0;
          after_separator = 1'b0;
          if (active) push_item(erfs_pkg::KIND_DATA, data);
        end else if (data == erfs_pkg::ESC_BYTE) begin
          escape_pending = 1'b1;
          after_separator = 1'b0;
        end else if (sep) begin
          if (active) begin
            close_field();
            after_separator = 1'b1;
          end
        end else begin
          after_separator = 1'b0;
          if (active) push_item(erfs_pkg::KIND_DATA, data);
        end
      end else begin
        open_final = 1'b1;
        if (data == erfs_pkg::RS_BYTE) begin
          open_final = !after_separator;
        end else if (escape_pending) begin
          if (active) push_item(erfs_pkg::KIND_DATA, data);
        end else if (data == erfs_pkg::ESC_BYTE) begin
          open_final = 1'b1;
        end else if (data == erfs_pkg::FS_BYTE) begin
          if (active) close_field();
          open_final = 1'b0;
        end else if (active) begin
          push_item(erfs_pkg::KIND_DATA, data);
        end
        if (open_final && fields_done < max_fields) close_field();
        push_item(erfs_pkg::KIND_RECORD_END, 8'h00);
        escape_pending = 1'b0;
        after_separator = 1'b0;
        fields_done = '0;
      end
      if (batch.size() > 0) batch[batch.size()-1].last = 1'b1;
      foreach (batch[i]) expected_items.push_back(batch[i]);
    endfunction

    task log_mismatch(string msg);
      $display("ERROR at %0t: %s", $realtime, msg);
      mismatches++;
    endtask

    task check_result(field_item_t got);
      field_item_t want;
      if (expected_items.size() == 0) begin
        log_mismatch($sformatf("unexpected result kind %0d byte %02h field %0d",
                               got.kind, got.value, got.field_no));
        return;
      end
      want = expected_items.pop_front();
      if (got.kind !== want.kind)
        log_mismatch($sformatf("item_kind %0d, expected %0d", got.kind, want.kind));
      if (got.value !== want.value)
        log_mismatch($sformatf("out_byte %02h, expected %02h", got.value, want.value));
      if (got.field_no !== want.field_no)
        log_mismatch($sformatf("field_number %0d, expected %0d", got.field_no, want.field_no));
      if (got.last !== want.last)
        log_mismatch($sformatf("run_last %0b, expected %0b", got.last, want.last));
    endtask
  endclass

  logic clk;
  logic rst;
  bit byte_up;
  bit in_burst;
  bit out_burst;
  int sent_count;

  erfs_byte_if byte_bus ();
  erfs_cfg_if cfg_bus ();
  erfs_item_if item_bus ();

  field_splitter_scoreboard board = new();

  escaped_record_field_splitter_unit i_dut (
    .clk(clk),
    .rst(rst),
    .byte_stream(byte_bus),
    .cfg(cfg_bus),
    .item_stream(item_bus)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  task send_byte(logic [erfs_pkg::BYTE_W-1:0] data, logic eor);
    int gap;
    gap = in_burst ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      if (byte_up) begin
        byte_bus.valid <= 1'b0;
        byte_up = 1'b0;
      end
      repeat (gap) @(posedge clk);
    end
    byte_bus.valid <= 1'b1;
    byte_bus.data_byte <= data;
    byte_bus.end_of_record <= eor;
    byte_up = 1'b1;
    do @(posedge clk); while (!byte_bus.ready);
    board.note_request(data, eor);
    sent_count++;
  endtask

  task send_record(logic [erfs_pkg::BYTE_W-1:0] bytes_q[$]);
    in_burst = ($urandom_range(0, 3) == 0);
    foreach (bytes_q[i]) send_byte(bytes_q[i], i == bytes_q.size() - 1);
  endtask

  function automatic logic [erfs_pkg::BYTE_W-1:0] draw_byte();
    case ($urandom_range(0, 9))
      0: return erfs_pkg::ESC_BYTE;
      1: return erfs_pkg::FS_BYTE;
      2: return erfs_pkg::RS_BYTE;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task send_random_record();
    logic [erfs_pkg::BYTE_W-1:0] rec[$];
    int len;
    len = $urandom_range(0, 10);
    repeat (len + 1) rec.push_back(draw_byte());
    send_record(rec);
  endtask

  task hold_until_drained(int settle);
    if (byte_up) begin
      byte_bus.valid <= 1'b0;
      byte_up = 1'b0;
    end
    @(posedge clk);
    while (board.pending()) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task write_max_fields(logic [erfs_pkg::BYTE_W-1:0] limit);
    hold_until_drained(8);
    cfg_bus.valid <= 1'b1;
    cfg_bus.max_fields <= limit;
    do @(posedge clk); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
    board.set_max_fields(limit);
  endtask

  task run_random_phase(int items);
    int target;
    target = sent_count + items;
    while (sent_count < target) begin
      if ($urandom_range(0, 19) == 0) hold_until_drained(0);
      send_random_record();
    end
  endtask

  initial begin : result_sink
    int stall;
    field_item_t got;
    item_bus.ready <= 1'b0;
    stall = 0;
    forever begin
      @(posedge clk);
      if (!rst) begin
        if (item_bus.valid && item_bus.ready) begin
          got = '{item_bus.item_kind, item_bus.out_byte, item_bus.field_number,
                  item_bus.run_last};
          board.check_result(got);
          if ($urandom_range(0, 29) == 0) out_burst = !out_burst;
          stall = out_burst ? 0 : $urandom_range(0, 16);
          if (stall != 0) item_bus.ready <= 1'b0;
        end else if (!item_bus.ready) begin
          if (stall > 0) stall--;
          if (stall == 0) item_bus.ready <= 1'b1;
        end
      end
    end
  end

  initial begin : stimulus
    logic [erfs_pkg::BYTE_W-1:0] rec[$];
    logic [erfs_pkg::BYTE_W-1:0] limits[$];
    rst <= 1'b1;
    byte_bus.valid <= 1'b0;
    byte_bus.data_byte <= '0;
    byte_bus.end_of_record <= 1'b0;
    cfg_bus.valid <= 1'b0;
    cfg_bus.max_fields <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    rec = '{8'h61, 8'h00, erfs_pkg::FS_BYTE, 8'hFF, erfs_pkg::RS_BYTE};
    send_record(rec);
    rec = '{erfs_pkg::RS_BYTE};
    send_record(rec);
    rec = '{erfs_pkg::ESC_BYTE};
    send_record(rec);
    rec = '{8'h41, erfs_pkg::ESC_BYTE, erfs_pkg::RS_BYTE};
    send_record(rec);
    rec = '{erfs_pkg::ESC_BYTE, erfs_pkg::FS_BYTE, erfs_pkg::ESC_BYTE, erfs_pkg::ESC_BYTE,
            erfs_pkg::ESC_BYTE, erfs_pkg::RS_BYTE, erfs_pkg::RS_BYTE, 8'h42,
            erfs_pkg::FS_BYTE};
    send_record(rec);
    rec = '{8'h43, erfs_pkg::FS_BYTE, erfs_pkg::RS_BYTE};
    send_record(rec);
    rec = '{erfs_pkg::ESC_BYTE, erfs_pkg::FS_BYTE};
    send_record(rec);

    run_random_phase(30);
    limits = '{8'd0, 8'd1, 8'd2, 8'd3, 8'd255, 8'($urandom_range(4, 254)),
               8'($urandom_range(0, 255)), erfs_pkg::MAX_FIELDS_RESET};
    foreach (limits[i]) begin
      write_max_fields(limits[i]);
      run_random_phase(30);
    end

    hold_until_drained(20);
    if (board.mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

>>> escaped_record_field_splitter_unit.f
hdl/erfs_pkg.sv
hdl/erfs_ifs.sv
hdl/erfs_front.sv
hdl/erfs_queue.sv
hdl/erfs_back.sv
hdl/escaped_record_field_splitter_unit.sv
tb/escaped_record_field_splitter_unit_tb.sv
